[sv/clt_pkg.sv]
// Shared types and constants for the compacting list table.
// No dependencies; every other file in this folder imports this package.
package clt_pkg;

    localparam int DEPTH    = 64;
    localparam int ELEM_W   = 32;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int IN_W     = 40;
    localparam int OUT_W    = 48;

    typedef enum logic [1:0] {
        FN_APPEND = 2'd0,
        FN_REMOVE = 2'd1,
        FN_GET    = 2'd2,
        FN_SET    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_CMP,
        FSM_SHIFT
    } fsm_t;

    // Per-cell control from the sequencer and the request decodes
    typedef struct packed {
        logic wr_en;
        logic live;
        logic sel;
        logic cmp_en;
        logic shift_en;
    } cell_ctrl_t;

endpackage

[sv/clt_cell.sv]
// One storage cell of the list: holds an entry, compares it with the key,
// and takes its right neighbor's entry when a removal closes the gap.
// Depends on clt_pkg.
module clt_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  clt_pkg::cell_ctrl_t       ctrl,
    input  logic [clt_pkg::ELEM_W-1:0] wdata,
    input  logic [clt_pkg::ELEM_W-1:0] key,
    input  logic [clt_pkg::ELEM_W-1:0] right_entry,
    input  logic                      seen_in,
    output logic                      seen_out,
    output logic [clt_pkg::ELEM_W-1:0] entry,
    output logic [clt_pkg::ELEM_W-1:0] rdata
);
    import clt_pkg::*;

    logic [ELEM_W-1:0] entry_reg;
    logic [ELEM_W-1:0] entry_next;
    logic              match_reg;
    logic              match_next;

    // A hit here or in any cell to the left shifts this cell down
    assign seen_out = seen_in | match_reg;
    assign entry    = entry_reg;
    assign rdata    = ctrl.sel ? entry_reg : '0;

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.cmp_en)
        begin
            match_next = ctrl.live && (entry_reg == key);
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.wr_en)
        begin
            entry_next = wdata;
        end
        else if (ctrl.shift_en && seen_out)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

endmodule

[sv/compacting_list_table_core.sv]
// Top level of the compacting list table: request/response stream ports,
// the sequencer, and the chain of clt_cell storage cells.
// Depends on clt_pkg and clt_cell.
//
//   channel   direction  tdata fields (low bit up)                      tuser
//   s_axis    in         func[1:0] position[7:2] value[39:8]            -
//   m_axis    out        status[1:0] read_value[33:2] count[40:34], pad -
//
// Append, get and set finish in the cycle of the transfer; remove steps
// through the transfer, the compare in every cell and the ripple of the
// first hit and shift, in the compare and shift states of the sequencer;
// the hit ripple settles inside the shift state.
// Reset clears the count, the sequencer and the result valid flag; entries stay
// undefined until written. A result waits in the output register; the next
// request can be taken in the same cycle that result is taken.
module compacting_list_table_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [clt_pkg::IN_W-1:0]   s_axis_tdata,  // func, position, value
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [clt_pkg::OUT_W-1:0]  m_axis_tdata   // status, read_value, count, zero pad
);
    import clt_pkg::*;

    // Request fields
    func_t              req_func;
    logic [POS_W-1:0]   req_pos;
    logic [VALUE_W-1:0] req_value;
    logic               accept;

    // Sequencer
    fsm_t state_reg;
    fsm_t state_next;
    logic cmp_en;
    logic shift_en;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ELEM_W-1:0] key_reg;
    logic [ELEM_W-1:0] key_next;

    // Output register
    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            out_status_reg;
    status_t            out_status_next;
    logic [VALUE_W-1:0] out_rd_reg;
    logic [VALUE_W-1:0] out_rd_next;
    logic [CNT_W-1:0]   out_count_reg;
    logic [CNT_W-1:0]   out_count_next;
    logic               out_load;

    // Cell chain
    cell_ctrl_t        ctrl   [DEPTH];
    logic [ELEM_W-1:0] entry  [DEPTH];
    logic [ELEM_W-1:0] rdata  [DEPTH];
    logic              seen   [DEPTH+1];
    logic [ELEM_W-1:0] rd_or;
    logic              full;
    logic              pos_ok;
    logic              found;

    assign req_func  = func_t'(s_axis_tdata[1:0]);
    assign req_pos   = s_axis_tdata[2 +: POS_W];
    assign req_value = s_axis_tdata[2 + POS_W +: VALUE_W];

    assign s_axis_tready = (state_reg == FSM_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign pos_ok = (CNT_W'(req_pos) < count_reg);
    assign found  = seen[DEPTH];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept && (req_func == FN_REMOVE))
                begin
                    state_next = FSM_CMP;
                end
            end
            FSM_CMP:   state_next = FSM_SHIFT;
            FSM_SHIFT: state_next = FSM_IDLE;
            default:   state_next = FSM_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        cmp_en   = 1'b0;
        shift_en = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            FSM_IDLE:  out_load = accept && (req_func != FN_REMOVE);
            FSM_CMP:   cmp_en   = 1'b1;
            FSM_SHIFT:
            begin
                shift_en = 1'b1;
                out_load = 1'b1;
            end
            default:   out_load = 1'b0;
        endcase
    end

    // Per-cell controls: independent decodes of count and position
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            always_comb
            begin
                ctrl[i].live     = (CNT_W'(i) < count_reg);
                ctrl[i].cmp_en   = cmp_en;
                ctrl[i].shift_en = shift_en;
                ctrl[i].sel      = (req_func == FN_GET) && pos_ok
                                   && (CNT_W'(i) == CNT_W'(req_pos));
                ctrl[i].wr_en    = accept
                                   && (((req_func == FN_APPEND) && !full
                                        && (CNT_W'(i) == count_reg))
                                    || ((req_func == FN_SET) && pos_ok
                                        && (CNT_W'(i) == CNT_W'(req_pos))));
            end

            clt_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl[i]),
                .wdata       (req_value[ELEM_W-1:0]),
                .key         (key_reg),
                .right_entry ((i == DEPTH - 1) ? entry[i] : entry[(i + 1) % DEPTH]),
                .seen_in     (seen[i]),
                .seen_out    (seen[i+1]),
                .entry       (entry[i]),
                .rdata       (rdata[i])
            );
        end
    endgenerate

    assign seen[0] = 1'b0;

    // Gather the selected entry for a get
    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_or = rd_or | rdata[i];
        end
    end

    // Result and count update
    always_comb
    begin
        count_next      = count_reg;
        key_next        = key_reg;
        out_status_next = out_status_reg;
        out_rd_next     = out_rd_reg;
        out_count_next  = out_count_reg;
        if (accept)
        begin
            key_next = req_value[ELEM_W-1:0];
        end
        if (state_reg == FSM_SHIFT)
        begin
            if (found)
            begin
                count_next      = count_reg - CNT_W'(1);
                out_status_next = ST_OK;
            end
            else
            begin
                out_status_next = ST_NOT_FOUND;
            end
            out_rd_next    = '0;
            out_count_next = count_next;
        end
        else if (out_load)
        begin
            out_rd_next = '0;
            unique case (req_func)
                FN_APPEND:
                begin
                    if (full)
                    begin
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        out_status_next = ST_OK;
                        count_next      = count_reg + CNT_W'(1);
                    end
                end
                FN_GET:
                begin
                    out_status_next = pos_ok ? ST_OK : ST_BAD_INDEX;
                    out_rd_next     = VALUE_W'(rd_or);
                end
                FN_SET:    out_status_next = pos_ok ? ST_OK : ST_BAD_INDEX;
                FN_REMOVE: out_status_next = ST_OK;
                default:   out_status_next = ST_OK;
            endcase
            out_count_next = count_next;
        end
    end

    // Hold a result until the downstream side takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        out_status_reg <= out_status_next;
        out_rd_reg     <= out_rd_next;
        out_count_reg  <= out_count_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_W - 2 - VALUE_W - CNT_W)'(0), out_count_reg,
                            out_rd_reg, out_status_reg};

endmodule

[sv/clt_checker.sv]
// Port-level checks for compacting_list_table_core, attached by bind.
// Depends on clt_pkg.
module clt_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [clt_pkg::IN_W-1:0]  s_axis_tdata,
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [clt_pkg::OUT_W-1:0] m_axis_tdata
);
    import clt_pkg::*;

    logic [1:0]         chk_status;
    logic [VALUE_W-1:0] chk_rd;
    logic [CNT_W-1:0]   chk_count;

    assign chk_status = m_axis_tdata[1:0];
    assign chk_rd     = m_axis_tdata[2 +: VALUE_W];
    assign chk_count  = m_axis_tdata[2 + VALUE_W +: CNT_W];

    // Count never goes past capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (chk_count <= CNT_W'(DEPTH)))
        else $error("count above capacity");

    // A request that fails carries a zero read value
    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (chk_status != ST_OK)) |-> (chk_rd == '0))
        else $error("read_value set on a failed request");

    // Full is only reported at capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (chk_status == ST_FULL)) |-> (chk_count == CNT_W'(DEPTH)))
        else $error("full status below capacity");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // A remove transfer blocks the next request while the cells compare
    a_remove_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == FN_REMOVE))
        |=> !s_axis_tready)
        else $error("request taken during a remove");

endmodule

bind compacting_list_table_core clt_checker u_clt_checker (.*);
